// ----- rtl/itsp_pkg.sv -----
// Shared types, codes and helper functions for the INT stack parser.
package itsp_pkg;

  localparam int unsigned MAX_HOPS = 64;
  localparam int unsigned HOP_CAP  = (MAX_HOPS > 127) ? 127 : MAX_HOPS;
  localparam logic [3:0]  ITEM_NONE = 4'd10;
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);

  typedef enum logic [3:0] {
    K_SWITCH_ID = 4'd0, K_IN_PORT = 4'd1, K_OUT_PORT = 4'd2, K_LATENCY = 4'd3,
    K_QUEUE_ID = 4'd4, K_OCCUPANCY = 4'd5, K_IN_TIME = 4'd6, K_OUT_TIME = 4'd7,
    K_LV2_IN = 4'd8, K_LV2_OUT = 4'd9, K_TX_UTIL = 4'd10, K_L4S_MARK = 4'd11,
    K_L4S_DROP = 4'd12, K_MARK_PROB = 4'd13, K_CLOUD = 4'd14, K_SUMMARY = 4'd15
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK = 2'd0, ST_HDR_TRUNC = 2'd1, ST_BAD_TYPE = 2'd2, ST_META_TRUNC = 2'd3
  } status_e;

  typedef struct packed {
    logic [31:0] word;
    logic        first_word;
    logic        last_word;
  } in_word_t;

  typedef struct packed {
    logic [3:0]  kind;
    logic [5:0]  hop_index;
    logic [63:0] value;
    logic [15:0] instruction_bits;
    logic [6:0]  hop_count;
    logic [31:0] sum_latency;
    logic [1:0]  status;
    logic        run_last;
  } result_t;

  // One parsed word: up to two data records and an optional summary.
  typedef struct packed {
    logic [1:0]  n_rec;
    logic [3:0]  kind0;
    logic [63:0] val0;
    logic [3:0]  kind1;
    logic [63:0] val1;
    logic [5:0]  hop;
    logic        sum;
    logic [15:0] bits;
    logic [6:0]  hops;
    logic [31:0] lat;
    logic [1:0]  status;
  } cmd_t;

  // Word count of a per-hop item (LV2 is item 6).
  function automatic logic [2:0] item_len(logic [3:0] it, logic wide);
    logic [2:0] l;
    case (it)
      4'd4, 4'd5, 4'd8: l = 3'd2;
      4'd6:             l = wide ? 3'd2 : 3'd1;
      4'd9:             l = 3'd7;
      default:          l = 3'd1;
    endcase
    return l;
  endfunction

  function automatic logic [4:0] hop_word_count(logic [15:0] bm);
    logic [4:0] s;
    s = '0;
    for (int i = 0; i < 10; i++) begin
      if (bm[15-i]) s = s + {2'b0, item_len(4'(i), 1'b0)};
    end
    return s;
  endfunction

  // First enabled item above it; ITEM_NONE if none.
  function automatic logic [3:0] next_item(logic [15:0] bm, logic [3:0] it);
    logic [3:0] r;
    r = ITEM_NONE;
    for (int i = 9; i >= 0; i--) begin
      if (i > int'(it) && bm[15-i]) r = 4'(i);
    end
    return r;
  endfunction

  function automatic logic [3:0] first_item(logic [15:0] bm);
    logic [3:0] r;
    r = ITEM_NONE;
    for (int i = 9; i >= 0; i--) begin
      if (bm[15-i]) r = 4'(i);
    end
    return r;
  endfunction

endpackage

// ----- rtl/itsp_cmd_fifo.sv -----
// Small queue of parsed words between the front and back parts.
module itsp_cmd_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            wr_i,
  input  itsp_pkg::cmd_t  wdata_i,
  input  logic            rd_i,
  output itsp_pkg::cmd_t  rdata_o,
  output logic            full_o,
  output logic            empty_o
);
  itsp_pkg::cmd_t mem_q [itsp_pkg::FIFO_DEPTH];
  logic [itsp_pkg::FIFO_AW-1:0] wp_q, rp_q;
  logic [itsp_pkg::FIFO_AW:0]   cnt_q;

  assign full_o  = (cnt_q == (itsp_pkg::FIFO_AW+1)'(itsp_pkg::FIFO_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (wr_i && !full_o) mem_q[wp_q] <= wdata_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (wr_i && !full_o) wp_q <= wp_q + 1'b1;
      if (rd_i && !empty_o) rp_q <= rp_q + 1'b1;
      cnt_q <= cnt_q + (itsp_pkg::FIFO_AW+1)'(wr_i && !full_o)
                     - (itsp_pkg::FIFO_AW+1)'(rd_i && !empty_o);
    end
  end
endmodule

// ----- rtl/itsp_front.sv -----
// Front part: header parsing, hop-count divide, metadata word classification.
module itsp_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               acc_i,
  input  itsp_pkg::in_word_t in_i,
  output logic               busy_o,
  output logic               cmd_wr_o,
  output itsp_pkg::cmd_t     cmd_o
);
  typedef enum logic [2:0] {PH_IDLE, PH_HBH0, PH_HBH1, PH_META, PH_DONE} phase_e;

  phase_e      phase_q, phase_d;
  logic [6:0]  hop_q, hop_d, hops_q, hops_d;
  logic [3:0]  item_q, item_d;
  logic [2:0]  sub_q, sub_d;
  logic [15:0] bm_q, bm_d;
  logic [7:0]  shim_q, shim_d;
  logic [4:0]  ml_q, ml_d;
  logic        wide_q, wide_d;
  logic [31:0] lat_q, lat_d, thi_q, thi_d;
  // restoring divider
  logic        dbusy_q, dbusy_d;
  logic [2:0]  dcnt_q, dcnt_d;
  logic [7:0]  dvd_q, dvd_d, quo_q, quo_d;
  logic [5:0]  rem_q, rem_d;
  logic [5:0]  rtry;

  itsp_pkg::cmd_t c;
  logic           wr;

  assign busy_o   = dbusy_q;
  assign cmd_wr_o = wr;
  assign cmd_o    = c;
  assign rtry     = {rem_q[4:0], dvd_q[7]};

  always_comb begin
    logic [31:0] w;
    logic [15:0] nbm;
    logic [4:0]  hw;
    logic [7:0]  q;
    logic [3:0]  nx;
    phase_d = phase_q; hop_d = hop_q; hops_d = hops_q; item_d = item_q; sub_d = sub_q;
    bm_d = bm_q; shim_d = shim_q; ml_d = ml_q; wide_d = wide_q; lat_d = lat_q;
    thi_d = thi_q;
    dbusy_d = dbusy_q; dcnt_d = dcnt_q; dvd_d = dvd_q; quo_d = quo_q; rem_d = rem_q;
    w = in_i.word; nbm = '0; hw = '0; q = '0; nx = '0;
    c = '0; wr = 1'b0;

    if (dbusy_q) begin
      if (rtry >= {1'b0, ml_q}) begin
        rem_d = rtry - {1'b0, ml_q};
        quo_d = {quo_q[6:0], 1'b1};
      end else begin
        rem_d = rtry;
        quo_d = {quo_q[6:0], 1'b0};
      end
      dvd_d  = {dvd_q[6:0], 1'b0};
      dcnt_d = dcnt_q + 1'b1;
      if (dcnt_q == 3'd7) dbusy_d = 1'b0;
    end

    if (acc_i) begin
      if (in_i.first_word) begin
        hop_d = '0; hops_d = '0; item_d = '0; sub_d = '0; bm_d = '0; ml_d = '0;
        wide_d = 1'b0; lat_d = '0; thi_d = '0;
        shim_d = w[15:8];
        c.bits = '0; c.hops = '0; c.lat = '0;
        if (w[31:24] > 8'd1) begin
          wr = 1'b1; c.sum = 1'b1; c.status = itsp_pkg::ST_BAD_TYPE;
          phase_d = PH_DONE;
        end else if (in_i.last_word) begin
          wr = 1'b1; c.sum = 1'b1; c.status = itsp_pkg::ST_HDR_TRUNC;
          phase_d = PH_DONE;
        end else begin
          phase_d = PH_HBH0;
        end
      end else begin
        case (phase_q)
          PH_HBH0: begin
            ml_d = w[12:8];
            phase_d = PH_HBH1;
            if (in_i.last_word) begin
              wr = 1'b1; c.sum = 1'b1; c.status = itsp_pkg::ST_HDR_TRUNC;
              c.bits = bm_q; c.hops = hops_q; c.lat = lat_q;
              phase_d = PH_DONE;
            end else begin
              dbusy_d = 1'b1; dcnt_d = '0; quo_d = '0; rem_d = '0;
              dvd_d = (shim_q >= 8'd3) ? shim_q - 8'd3 : 8'd0;
            end
          end
          PH_HBH1: begin
            nbm = w[31:16];
            bm_d = nbm;
            q = (shim_q < 8'd3 || ml_q == '0) ? 8'd0 : quo_q;
            hops_d = (q > 8'(itsp_pkg::HOP_CAP)) ? 7'(itsp_pkg::HOP_CAP) : q[6:0];
            hw = itsp_pkg::hop_word_count(nbm);
            wide_d = nbm[15-6] && (ml_q == hw + 5'd1);
            item_d = itsp_pkg::first_item(nbm);
            sub_d = '0; hop_d = '0;
            c.bits = nbm; c.hops = hops_d; c.lat = lat_q;
            if (hops_d == '0 || hw == '0) begin
              wr = 1'b1; c.sum = 1'b1; c.status = itsp_pkg::ST_OK; phase_d = PH_DONE;
            end else begin
              phase_d = PH_META;
              if (in_i.last_word) begin
                wr = 1'b1; c.sum = 1'b1; c.status = itsp_pkg::ST_META_TRUNC;
                phase_d = PH_DONE;
              end
            end
          end
          PH_META: begin
            c.hop = hop_q[5:0];
            case (item_q)
              4'd0: begin c.n_rec = 2'd1; c.kind0 = itsp_pkg::K_SWITCH_ID; c.val0 = 64'(w); end
              4'd1: begin
                c.n_rec = 2'd2; c.kind0 = itsp_pkg::K_IN_PORT; c.val0 = 64'(w[31:16]);
                c.kind1 = itsp_pkg::K_OUT_PORT; c.val1 = 64'(w[15:0]);
              end
              4'd2: begin
                c.n_rec = 2'd1; c.kind0 = itsp_pkg::K_LATENCY; c.val0 = 64'(w);
                lat_d = lat_q + w;
              end
              4'd3: begin
                c.n_rec = 2'd2; c.kind0 = itsp_pkg::K_QUEUE_ID; c.val0 = 64'(w[31:24]);
                c.kind1 = itsp_pkg::K_OCCUPANCY; c.val1 = 64'(w[23:0]);
              end
              4'd4, 4'd5: begin
                if (sub_q == '0) thi_d = w;
                else begin
                  c.n_rec = 2'd1; c.val0 = {thi_q, w};
                  c.kind0 = (item_q == 4'd4) ? itsp_pkg::K_IN_TIME : itsp_pkg::K_OUT_TIME;
                end
              end
              4'd6: begin
                if (wide_q) begin
                  c.n_rec = 2'd1; c.val0 = 64'(w);
                  c.kind0 = (sub_q == '0) ? itsp_pkg::K_LV2_IN : itsp_pkg::K_LV2_OUT;
                end else begin
                  c.n_rec = 2'd2; c.kind0 = itsp_pkg::K_LV2_IN; c.val0 = 64'(w[31:16]);
                  c.kind1 = itsp_pkg::K_LV2_OUT; c.val1 = 64'(w[15:0]);
                end
              end
              4'd7: begin c.n_rec = 2'd1; c.kind0 = itsp_pkg::K_TX_UTIL; c.val0 = 64'(w); end
              4'd8: begin
                if (sub_q == '0) begin
                  c.n_rec = 2'd2; c.kind0 = itsp_pkg::K_L4S_MARK; c.val0 = 64'(w[31:16]);
                  c.kind1 = itsp_pkg::K_L4S_DROP; c.val1 = 64'(w[15:0]);
                end else begin
                  c.n_rec = 2'd1; c.kind0 = itsp_pkg::K_MARK_PROB; c.val0 = 64'(w);
                end
              end
              4'd9: begin c.n_rec = 2'd1; c.kind0 = itsp_pkg::K_CLOUD; c.val0 = 64'(w); end
              default: ;
            endcase
            // step to the next word of the hop, wrapping to the next hop
            if (sub_q + 3'd1 < itsp_pkg::item_len(item_q, wide_q)) begin
              sub_d = sub_q + 3'd1;
            end else begin
              sub_d = '0;
              nx = itsp_pkg::next_item(bm_q, item_q);
              if (nx == itsp_pkg::ITEM_NONE) begin
                hop_d = hop_q + 7'd1;
                item_d = itsp_pkg::first_item(bm_q);
              end else begin
                item_d = nx;
              end
            end
            c.bits = bm_q; c.hops = hops_q; c.lat = lat_d;
            if (hop_d >= hops_q) begin
              c.sum = 1'b1; c.status = itsp_pkg::ST_OK; phase_d = PH_DONE;
            end else if (in_i.last_word) begin
              c.sum = 1'b1; c.status = itsp_pkg::ST_META_TRUNC; phase_d = PH_DONE;
            end
            wr = c.sum || (c.n_rec != '0);
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE; hop_q <= '0; hops_q <= '0; item_q <= '0; sub_q <= '0;
      bm_q <= '0; shim_q <= '0; ml_q <= '0; wide_q <= 1'b0; lat_q <= '0; thi_q <= '0;
      dbusy_q <= 1'b0; dcnt_q <= '0; dvd_q <= '0; quo_q <= '0; rem_q <= '0;
    end else begin
      phase_q <= phase_d; hop_q <= hop_d; hops_q <= hops_d; item_q <= item_d;
      sub_q <= sub_d; bm_q <= bm_d; shim_q <= shim_d; ml_q <= ml_d; wide_q <= wide_d;
      lat_q <= lat_d; thi_q <= thi_d;
      dbusy_q <= dbusy_d; dcnt_q <= dcnt_d; dvd_q <= dvd_d; quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end
endmodule

// ----- rtl/itsp_back.sv -----
// Back part: expands queued parse commands into result words.
module itsp_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  itsp_pkg::cmd_t    cmd_i,
  input  logic              cmd_empty_i,
  output logic              cmd_rd_o,
  input  logic              pop_i,
  output logic              empty_o,
  output itsp_pkg::result_t result_o
);
  itsp_pkg::cmd_t    ent_q, ent_d;
  logic              ent_v_q, ent_v_d;
  logic [1:0]        pos_q, pos_d;
  itsp_pkg::result_t out_q, out_d, r;
  logic              out_v_q, out_v_d;
  logic              take, load, done;
  logic [1:0]        cnt;

  assign empty_o  = !out_v_q;
  assign result_o = out_q;
  assign take     = pop_i && out_v_q;
  assign cnt      = ent_q.n_rec + 2'(ent_q.sum);
  assign load     = ent_v_q && (!out_v_q || take);
  assign done     = load && (pos_q == cnt - 2'd1);
  assign cmd_rd_o = (!ent_v_q || done) && !cmd_empty_i;

  always_comb begin
    r = '0;
    if (pos_q < ent_q.n_rec) begin
      r.hop_index = ent_q.hop;
      r.kind  = (pos_q == '0) ? ent_q.kind0 : ent_q.kind1;
      r.value = (pos_q == '0) ? ent_q.val0 : ent_q.val1;
    end else begin
      r.kind = itsp_pkg::K_SUMMARY;
      r.instruction_bits = ent_q.bits;
      r.hop_count = ent_q.hops;
      r.sum_latency = ent_q.lat;
      r.status = ent_q.status;
      r.run_last = 1'b1;
    end
    out_d = load ? r : out_q;
    out_v_d = load ? 1'b1 : (take ? 1'b0 : out_v_q);
    ent_d = ent_q; ent_v_d = ent_v_q; pos_d = pos_q;
    if (load) pos_d = pos_q + 2'd1;
    if (done) ent_v_d = 1'b0;
    if (cmd_rd_o) begin
      ent_d = cmd_i; ent_v_d = 1'b1; pos_d = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
    out_q <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_v_q <= 1'b0; pos_q <= '0; out_v_q <= 1'b0;
    end else begin
      ent_v_q <= ent_v_d; pos_q <= pos_d; out_v_q <= out_v_d;
    end
  end
endmodule

// ----- rtl/int_telemetry_stack_parser.sv -----
// Top level of the INT metadata stack parser: front, command queue, back.
//
//  channel  | handshake          | payload
//  ---------+--------------------+---------------------------------
//  input    | push / full        | word_i   (itsp_pkg::in_word_t)
//  result   | pop / empty        | result_o (itsp_pkg::result_t)
//
// One word per cycle is taken while the command queue has room, except after the first
// hop-by-hop header word: full stays high while the bit-serial divider forms the hop count.
// Each word yields 0 to 3 results, drained one per cycle by the back part while pop is high;
// a 4-entry command queue lets the front run ahead of a stalled result side.
// Reset clears all parse state; a first_word restarts parsing at any time.
module int_telemetry_stack_parser (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push,
  output logic              full,
  input  itsp_pkg::in_word_t word_i,
  output logic              empty,
  input  logic              pop,
  output itsp_pkg::result_t result_o
);
  logic           busy, acc;
  logic           cwr, crd, cfull, cempty;
  itsp_pkg::cmd_t cwdata, crdata;

  // queue full blocks every word, even ones that make no command
  assign full = cfull || busy;
  assign acc  = push && !full;

  itsp_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .acc_i    (acc),
    .in_i     (word_i),
    .busy_o   (busy),
    .cmd_wr_o (cwr),
    .cmd_o    (cwdata)
  );

  itsp_cmd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (cwr),
    .wdata_i (cwdata),
    .rd_i    (crd),
    .rdata_o (crdata),
    .full_o  (cfull),
    .empty_o (cempty)
  );

  itsp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (crdata),
    .cmd_empty_i (cempty),
    .cmd_rd_o    (crd),
    .pop_i       (pop),
    .empty_o     (empty),
    .result_o    (result_o)
  );
endmodule

// ----- test/tb_int_telemetry_stack_parser.sv -----
// Testbench for the INT metadata stack parser: directed and random packets checked against a predictor.
module tb_int_telemetry_stack_parser;

  logic               clk_i;
  logic               rst_ni;
  logic               push;
  logic               full;
  itsp_pkg::in_word_t word_i;
  logic               empty;
  logic               pop;
  itsp_pkg::result_t  result_o;

  int_telemetry_stack_parser DUT (
    .clk_i(clk_i), .rst_ni(rst_ni), .push(push), .full(full), .word_i(word_i),
    .empty(empty), .pop(pop), .result_o(result_o)
  );

  // parse phases of the predictor
  typedef enum logic [2:0] {
    PH_IDLE, PH_HBH0, PH_HBH1, PH_META, PH_DONE
  } phase_e;

  // predictor state
  phase_e      ph;
  logic [6:0]  hop_ctr;
  logic [4:0]  step_ctr;
  logic [15:0] bitmap;
  logic [7:0]  shim_len;
  logic [4:0]  hop_ml;
  logic [6:0]  hops_tot;
  logic        lv2_wide;
  logic [31:0] lat_sum;
  logic [31:0] ts_high;

  itsp_pkg::result_t  expected_results[$];
  itsp_pkg::in_word_t pending_words[$];
  int       errors;
  int       words_sent;
  int       results_seen;
  int       packets_sent;
  longint   cycles;
  int       in_gap;
  int       out_gap;
  bit       in_taken;

  function automatic int unsigned word_len(int unsigned it);
    case (it)
      4, 5, 8: return 2;
      6:       return lv2_wide ? 2 : 1;
      9:       return 7;
      default: return 1;
    endcase
  endfunction

  function automatic bit item_on(int unsigned it);
    return bitmap[15 - it];
  endfunction

  function automatic int unsigned words_per_hop();
    int unsigned s;
    s = 0;
    for (int unsigned i = 0; i < 10; i++) if (item_on(i)) s += word_len(i);
    return s;
  endfunction

  task automatic add_record(logic [3:0] k, logic [63:0] v);
    itsp_pkg::result_t r;
    r = '0;
    r.kind = k;
    r.hop_index = hop_ctr[5:0];
    r.value = v;
    expected_results.push_back(r);
  endtask

  task automatic close_packet(itsp_pkg::status_e st);
    itsp_pkg::result_t r;
    r = '0;
    r.kind = itsp_pkg::K_SUMMARY;
    r.instruction_bits = bitmap;
    r.hop_count = hops_tot;
    r.sum_latency = lat_sum;
    r.status = st;
    r.run_last = 1'b1;
    expected_results.push_back(r);
    ph = PH_DONE;
  endtask

  task automatic clear_parse();
    ph = PH_IDLE; hop_ctr = '0; step_ctr = '0; bitmap = '0; shim_len = '0;
    hop_ml = '0; hops_tot = '0; lv2_wide = 1'b0; lat_sum = '0; ts_high = '0;
  endtask

  // one metadata word: locate the item and sub-word from the step counter
  task automatic parse_meta(logic [31:0] w);
    int unsigned st, it, sub;
    st = step_ctr; it = 10; sub = 0;
    for (int unsigned i = 0; i < 10; i++) begin
      if (item_on(i)) begin
        if (it == 10 && st < word_len(i)) begin
          it = i; sub = st;
        end else if (it == 10) begin
          st -= word_len(i);
        end
      end
    end
    case (it)
      0: add_record(itsp_pkg::K_SWITCH_ID, w);
      1: begin
        add_record(itsp_pkg::K_IN_PORT, w[31:16]);
        add_record(itsp_pkg::K_OUT_PORT, w[15:0]);
      end
      2: begin add_record(itsp_pkg::K_LATENCY, w); lat_sum += w; end
      3: begin
        add_record(itsp_pkg::K_QUEUE_ID, w[31:24]);
        add_record(itsp_pkg::K_OCCUPANCY, w[23:0]);
      end
      4, 5: begin
        if (sub == 0) ts_high = w;
        else add_record(it == 4 ? itsp_pkg::K_IN_TIME : itsp_pkg::K_OUT_TIME, {ts_high, w});
      end
      6: begin
        if (lv2_wide) add_record(sub == 0 ? itsp_pkg::K_LV2_IN : itsp_pkg::K_LV2_OUT, w);
        else begin
          add_record(itsp_pkg::K_LV2_IN, w[31:16]);
          add_record(itsp_pkg::K_LV2_OUT, w[15:0]);
        end
      end
      7: add_record(itsp_pkg::K_TX_UTIL, w);
      8: begin
        if (sub == 0) begin
          add_record(itsp_pkg::K_L4S_MARK, w[31:16]);
          add_record(itsp_pkg::K_L4S_DROP, w[15:0]);
        end else add_record(itsp_pkg::K_MARK_PROB, w);
      end
      9: add_record(itsp_pkg::K_CLOUD, w);
      default: ;
    endcase
    step_ctr = step_ctr + 5'd1;
    if (step_ctr >= words_per_hop()) begin
      step_ctr = '0;
      hop_ctr = hop_ctr + 7'd1;
    end
  endtask

  task automatic predict_word(itsp_pkg::in_word_t iw);
    int unsigned hops, hw;
    if (iw.first_word) begin
      clear_parse();
      shim_len = iw.word[15:8];
      if (iw.word[31:24] > 1) close_packet(itsp_pkg::ST_BAD_TYPE);
      else begin
        ph = PH_HBH0;
        if (iw.last_word) close_packet(itsp_pkg::ST_HDR_TRUNC);
      end
    end else begin
      case (ph)
        PH_HBH0: begin
          hop_ml = iw.word[12:8];
          ph = PH_HBH1;
          if (iw.last_word) close_packet(itsp_pkg::ST_HDR_TRUNC);
        end
        PH_HBH1: begin
          bitmap = iw.word[31:16];
          hops = 0;
          if (shim_len >= 3 && hop_ml != 0) hops = (shim_len - 3) / hop_ml;
          if (hops > itsp_pkg::MAX_HOPS) hops = itsp_pkg::MAX_HOPS;
          if (hops > 127) hops = 127;
          hops_tot = hops;
          lv2_wide = 1'b0;
          hw = words_per_hop();
          if (item_on(6) && hop_ml == hw + 1) lv2_wide = 1'b1;
          if (hops_tot == 0 || hw == 0) close_packet(itsp_pkg::ST_OK);
          else begin
            ph = PH_META;
            if (iw.last_word) close_packet(itsp_pkg::ST_META_TRUNC);
          end
        end
        PH_META: begin
          parse_meta(iw.word);
          if (hop_ctr >= hops_tot) close_packet(itsp_pkg::ST_OK);
          else if (iw.last_word) close_packet(itsp_pkg::ST_META_TRUNC);
        end
        default: ;
      endcase
    end
  endtask

  function automatic itsp_pkg::in_word_t mk(logic [31:0] w, bit f, bit l);
    itsp_pkg::in_word_t x;
    x.word = w; x.first_word = f; x.last_word = l;
    return x;
  endfunction

  // Queue one packet. nhops/ml/bm set the header; cut truncates the word count
  // (negative = complete plus some trailing words).
  task automatic queue_packet(logic [7:0] typ, int unsigned nhops, logic [4:0] ml,
                              logic [15:0] bm, int cut);
    int unsigned hw, total, len;
    logic [31:0] w;
    hw = 0;
    for (int unsigned i = 0; i < 10; i++)
      if (bm[15 - i]) hw += (i == 4 || i == 5 || i == 8) ? 2 : (i == 9 ? 7 : 1);
    if (ml == 5'd0 && $urandom_range(0, 3) != 0) ml = hw[4:0];
    len = 3 + nhops * ml;
    if (len > 255) len = 255;
    total = 3 + nhops * hw;
    if (cut > 0 && cut < total) total = cut;
    else if (cut < 0) total = total - cut;
    for (int unsigned k = 0; k < total; k++) begin
      case (k)
        0: w = {typ, 8'($urandom), len[7:0], 8'($urandom)};
        1: w = {19'($urandom), ml, 8'($urandom)};
        2: w = {bm, 16'($urandom)};
        default: w = $urandom;
      endcase
      pending_words.push_back(mk(w, k == 0, k == total - 1));
    end
    packets_sent++;
  endtask

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // driver: changes inputs on the falling edge, holds a word until accepted
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!push || in_taken) begin
        if (in_gap > 0) begin
          in_gap--;
          push <= 1'b0;
        end else if (pending_words.size() != 0 && $urandom_range(0, 3) != 0) begin
          word_i <= pending_words.pop_front();
          push <= 1'b1;
          // mostly short gaps; now and then a long one
          if ($urandom_range(0, 40) == 0) in_gap = $urandom_range(5, 30);
        end else push <= 1'b0;
      end
      // result side stalls
      if (out_gap > 0) begin
        out_gap--;
        pop <= 1'b0;
      end else if ($urandom_range(0, 50) == 0) begin
        out_gap = $urandom_range(5, 30);
        pop <= 1'b0;
      end else pop <= ($urandom_range(0, 3) != 0);
    end
  end

  // monitor: sample at the rising edge; predict on accept, check on pop
  always @(posedge clk_i) begin
    in_taken = rst_ni && push && !full;
    if (rst_ni) begin
      cycles++;
      if (push && !full) begin
        predict_word(word_i);
        words_sent++;
      end
      if (pop && !empty) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          $error("result with nothing expected: kind %0d", result_o.kind);
          errors++;
        end else begin
          itsp_pkg::result_t e;
          e = expected_results.pop_front();
          if (result_o.kind !== e.kind) begin
            $error("kind exp %0d got %0d", e.kind, result_o.kind); errors++;
          end
          if (result_o.hop_index !== e.hop_index) begin
            $error("hop_index exp %0d got %0d", e.hop_index, result_o.hop_index); errors++;
          end
          if (result_o.value !== e.value) begin
            $error("value exp %h got %h", e.value, result_o.value); errors++;
          end
          if (result_o.instruction_bits !== e.instruction_bits) begin
            $error("instruction_bits exp %h got %h", e.instruction_bits,
                   result_o.instruction_bits); errors++;
          end
          if (result_o.hop_count !== e.hop_count) begin
            $error("hop_count exp %0d got %0d", e.hop_count, result_o.hop_count); errors++;
          end
          if (result_o.sum_latency !== e.sum_latency) begin
            $error("sum_latency exp %h got %h", e.sum_latency,
                   result_o.sum_latency); errors++;
          end
          if (result_o.status !== e.status) begin
            $error("status exp %0d got %0d", e.status, result_o.status); errors++;
          end
          if (result_o.run_last !== e.run_last) begin
            $error("run_last exp %0d got %0d", e.run_last, result_o.run_last); errors++;
          end
        end
      end
      if (cycles > 200000) begin
        $display("timeout after %0d cycles", cycles);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin
    int unsigned np, pick;
    rst_ni = 1'b0; push = 1'b0; pop = 1'b0; word_i = '0;
    errors = 0; words_sent = 0; results_seen = 0; packets_sent = 0; cycles = 0;
    in_gap = 0; out_gap = 0; in_taken = 1'b0;
    clear_parse();

    // Directed: bad type, short header, no hops, caps, truncation, restarts,
    // stray words, field extremes.
    queue_packet(8'hff, 1, 5'd1, 16'hffff, 0);                   // unsupported type
    pending_words.push_back(mk(32'hffff_ffff, 1'b0, 1'b1));      // stray word
    queue_packet(8'h01, 1, 5'd2, 16'h8000, 1);                   // only the shim
    queue_packet(8'h00, 1, 5'd2, 16'h8000, 2);                   // shim + hbh0
    queue_packet(8'h00, 0, 5'd0, 16'hffc0, 0);                   // length 3, no hops
    queue_packet(8'h00, 2, 5'd4, 16'h0000, 0);                   // zero hop words
    queue_packet(8'h00, 1, 5'd2, 16'hffc0, 3);                   // meta cut at once
    queue_packet(8'h00, 2, 5'd3, 16'hf000, 5);                   // meta cut mid hop
    queue_packet(8'h01, 1, 5'd20, 16'hff00, -2);                 // items 0-7, trailing
    queue_packet(8'h00, 2, 5'd3, 16'h0200, 0);                   // narrow LV2
    queue_packet(8'h00, 2, 5'd2, 16'h0200, 0);                   // wide LV2, cut short
    queue_packet(8'h00, 1, 5'd1, 16'h00c0, 0);                   // cloud + l4s
    queue_packet(8'h00, 84, 5'd3, 16'h2000, 0);                  // hop cap at 64
    queue_packet(8'h00, 2, 5'd1, 16'h8000, 4);                   // restart below
    queue_packet(8'h00, 1, 5'd31, 16'h3000, 0);                  // hop_ml max
    repeat (3) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    // Random packets until at least 265 words have been sent or queued.
    np = 0;
    while (np < 265) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        queue_packet(8'($urandom), $urandom_range(0, 3), 5'($urandom),
                     16'($urandom), $urandom_range(0, 6));
      end else if (pick == 1) begin
        pending_words.push_back(mk($urandom, 1'b0, 1'($urandom)));
        packets_sent++;
      end else begin
        queue_packet(8'($urandom_range(0, 1)), $urandom_range(1, 3), 5'd0,
                     16'($urandom) & 16'hffc0 | 16'($urandom),
                     ($urandom_range(0, 4) == 0) ? $urandom_range(1, 8) : 0);
      end
      np = words_sent + pending_words.size();
    end

    while (pending_words.size() != 0 || push) @(posedge clk_i);
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);

    $display("Sent %0d words in %0d packets or fragments; checked %0d results.",
             words_sent, packets_sent, results_seen);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule

// ----- sim.f -----
rtl/itsp_pkg.sv
rtl/itsp_cmd_fifo.sv
rtl/itsp_front.sv
rtl/itsp_back.sv
rtl/int_telemetry_stack_parser.sv
test/tb_int_telemetry_stack_parser.sv
